[rtl/sha_pkg.sv]
package sha_pkg;

    typedef struct packed {
        logic write_byte;
        logic write_pad;
        logic clear_tail;
        logic write_len;
        logic start_comp;
        logic round_step;
        logic finish_comp;
        logic load_iv;
        logic clear_count;
    } sha_cmd_t;

    typedef struct packed {
        logic       block_full;
        logic       tail_over;
        logic       rounds_done;
    } sha_stat_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_VEC [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[rtl/sha_datapath.sv]
module sha_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::sha_cmd_t  cmd,
    input  logic [7:0]         data_byte,
    output sha_pkg::sha_stat_t stat,
    output logic [255:0]       digest
);
    import sha_pkg::*;

    logic [31:0] buf_reg [16];
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  round_reg;
    logic [63:0] bits;
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] s0w;
    logic [31:0] s1w;
    logic [31:0] t1;
    logic [31:0] t2;

    assign bits = {count_reg, 3'b000};
    assign s0w = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1w = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0w + w_reg[9] + s1w;
    assign w_cur = w_reg[0];
    assign t1 = v_reg[7] + (ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25))
        + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[round_reg] + w_cur;
    assign t2 = (ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22))
        + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign stat.block_full  = (fill_reg == 6'd63);
    assign stat.tail_over   = (fill_reg > 6'd55);
    assign stat.rounds_done = (round_reg == 6'd63);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digest[255 - 32 * i -: 32] = hash_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_VEC[i];
            end
        end
        else
        begin
            if (cmd.write_byte)
            begin
                fill_reg  <= fill_reg + 6'd1;
                count_reg <= count_reg + 61'd1;
            end
            if (cmd.clear_count)
            begin
                fill_reg  <= '0;
                count_reg <= '0;
            end
            if (cmd.start_comp)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_step)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.finish_comp)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end
            if (cmd.load_iv)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= INIT_VEC[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            buf_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= data_byte;
        end
        if (cmd.write_pad)
        begin
            for (int j = 0; j < 16; j++)
            begin
                for (int b = 0; b < 4; b++)
                begin
                    if (6'(4 * j + b) == fill_reg)
                    begin
                        buf_reg[j][31 - 8 * b -: 8] <= PAD_BYTE;
                    end
                    else if (6'(4 * j + b) > fill_reg)
                    begin
                        buf_reg[j][31 - 8 * b -: 8] <= '0;
                    end
                end
            end
        end
        if (cmd.clear_tail)
        begin
            for (int j = 0; j < 16; j++)
            begin
                buf_reg[j] <= '0;
            end
        end
        if (cmd.write_len)
        begin
            buf_reg[14] <= bits[63:32];
            buf_reg[15] <= bits[31:0];
        end
        if (cmd.start_comp)
        begin
            for (int t = 0; t < 16; t++)
            begin
                w_reg[t] <= buf_reg[t];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round_step)
        begin
            for (int t = 0; t < 15; t++)
            begin
                w_reg[t] <= w_reg[t + 1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

[rtl/sha_ctrl.sv]
module sha_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               byte_present,
    input  logic               last_byte,
    input  sha_pkg::sha_stat_t stat,
    output sha_pkg::sha_cmd_t  cmd,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         word_index,
    output logic               last_word
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_ROUNDS, S_FINISH, S_PAD, S_LEN, S_OUT
    } state_t;

    state_t     state_reg;
    logic       last_reg;
    logic       final_reg;
    logic       second_reg;
    logic [1:0] idx_reg;
    logic       take;

    assign in_stall   = (state_reg != S_IDLE);
    assign take       = in_valid && (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 2'd3);

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.write_byte = take && byte_present;
            end
            S_PAD:
            begin
                cmd.write_pad = 1'b1;
            end
            S_LEN:
            begin
                cmd.write_len = 1'b1;
            end
            S_START:
            begin
                cmd.start_comp = 1'b1;
            end
            S_ROUNDS:
            begin
                cmd.round_step = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish_comp = 1'b1;
                cmd.clear_tail  = second_reg;
            end
            S_OUT:
            begin
                cmd.load_iv     = !out_stall && (idx_reg == 2'd3);
                cmd.clear_count = cmd.load_iv;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            last_reg   <= 1'b0;
            final_reg  <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        last_reg   <= last_byte;
                        final_reg  <= 1'b0;
                        second_reg <= 1'b0;
                        if (byte_present && stat.block_full)
                        begin
                            state_reg <= S_START;
                        end
                        else if (last_byte)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    if (stat.tail_over)
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= S_START;
                    end
                    else
                    begin
                        state_reg <= S_LEN;
                    end
                end
                S_LEN:
                begin
                    final_reg <= 1'b1;
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_ROUNDS;
                end
                S_ROUNDS:
                begin
                    if (stat.rounds_done)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    second_reg <= 1'b0;
                    if (final_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (second_reg)
                    begin
                        state_reg <= S_LEN;
                    end
                    else if (last_reg)
                    begin
                        state_reg <= S_PAD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> final_reg)
        else $error("digest beat without final block");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUNDS) |-> in_stall)
        else $error("input taken during rounds");
    a_rounds_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUNDS && stat.rounds_done) |=> (state_reg == S_FINISH))
        else $error("rounds did not finish");
`endif

endmodule

[rtl/sha256_stream_hasher_top.sv]
// A byte that fills no block is written as it is taken; a full block is then compressed.
// A last beat adds padding, one or two compressions and four digest beats.
// Throughput: one byte per cycle while in_stall is low; one round unit serves each 64-byte block.
// Reset (rst_n, asynchronous, active low) loads the initial hash and clears the counts.
module sha256_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;

    sha_cmd_t     cmd;
    sha_stat_t    stat;
    logic [255:0] digest;

    sha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .byte_present(byte_present), .last_byte(last_byte), .stat(stat), .cmd(cmd),
        .out_valid(out_valid), .out_stall(out_stall), .word_index(word_index),
        .last_word(last_word)
    );

    sha_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(data_byte), .stat(stat),
        .digest(digest)
    );

    assign digest_word = digest[255 - 64 * word_index -: 64];

endmodule
